### src/sle_pkg.sv
// Shared types and constants for the sequential list engine.
// No dependencies; every other file refers to this package by scoped names.
package sle_pkg;

	localparam int DEF_CAPACITY   = 128;
	localparam int DEF_DATA_WIDTH = 32;
	localparam int OPC_W          = 2;
	localparam int POS_W          = 8;
	localparam int VAL_W          = 32;

	typedef enum logic [OPC_W-1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_GET    = 2'd2,
		OP_LOCATE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		SH_HOLD,
		SH_INSERT,
		SH_DELETE
	} shift_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	// Broadcast from the controller to every cell.
	typedef struct packed {
		shift_t shift;
		logic   qget;
	} cell_ctl_t;

endpackage

### src/sle_req_if.sv
// Request channel of the sequential list engine: valid/ready plus the request fields.
// Depends on sle_pkg for the field widths.
interface sle_req_if;
	logic                       valid;
	logic                       ready;
	logic [sle_pkg::OPC_W-1:0]  opcode;
	logic [sle_pkg::POS_W-1:0]  position;
	logic signed [sle_pkg::VAL_W-1:0] item_value;

	modport source (output valid, output opcode, output position, output item_value,
		input ready);
	modport sink (input valid, input opcode, input position, input item_value,
		output ready);
endinterface

### src/sle_rsp_if.sv
// Response channel of the sequential list engine: valid/ready plus the result fields.
// Depends on sle_pkg for the field widths.
interface sle_rsp_if;
	logic                       valid;
	logic                       ready;
	logic                       status_error;
	logic signed [sle_pkg::VAL_W-1:0] read_value;
	logic [sle_pkg::POS_W-1:0]  found_position;
	logic [sle_pkg::POS_W-1:0]  current_length;

	modport source (output valid, output status_error, output read_value,
		output found_position, output current_length, input ready);
	modport sink (input valid, input status_error, input read_value,
		input found_position, input current_length, output ready);
endinterface

### src/sle_cell.sv
// One list cell: holds one entry, shifts with its neighbors and examines a passing scan token.
// Depends on sle_pkg for the control struct.
module sle_cell #(
	parameter int DATA_WIDTH = sle_pkg::DEF_DATA_WIDTH,
	parameter int LW         = 8,
	parameter int INDEX      = 0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sle_pkg::cell_ctl_t     ctl,
	input  logic [LW-1:0]          pos0,
	input  logic [DATA_WIDTH-1:0]  wdata,
	input  logic [LW-1:0]          len,
	input  logic [DATA_WIDTH-1:0]  left,
	input  logic [DATA_WIDTH-1:0]  right,
	output logic [DATA_WIDTH-1:0]  data,
	input  logic                   scan_vld_in,
	input  logic [LW-1:0]          scan_found_in,
	input  logic [DATA_WIDTH-1:0]  scan_rdata_in,
	output logic                   scan_vld_out,
	output logic [LW-1:0]          scan_found_out,
	output logic [DATA_WIDTH-1:0]  scan_rdata_out
);

	localparam logic [LW-1:0] IDX = LW'(INDEX);

	logic [DATA_WIDTH-1:0] data_q;
	logic                  scan_vld_q;
	logic [LW-1:0]         found_q;
	logic [DATA_WIDTH-1:0] rdata_q;
	logic                  hit;

	assign hit = !ctl.qget && (scan_found_in == '0) && (IDX < len) && (data_q == wdata);

	always_ff @(posedge clk) begin
		unique case (ctl.shift)
			sle_pkg::SH_INSERT: begin
				if (IDX == pos0) data_q <= wdata;
				else if (IDX > pos0) data_q <= left;
			end
			sle_pkg::SH_DELETE: begin
				if (IDX >= pos0) data_q <= right;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_vld_q <= 1'b0;
		end else begin
			scan_vld_q <= scan_vld_in;
		end
	end

	// The token carries the first match found so far; later cells leave it alone.
	always_ff @(posedge clk) begin
		found_q <= hit ? LW'(INDEX + 1) : scan_found_in;
		rdata_q <= (ctl.qget && IDX == pos0) ? data_q : scan_rdata_in;
	end

	assign data           = data_q;
	assign scan_vld_out   = scan_vld_q;
	assign scan_found_out = found_q;
	assign scan_rdata_out = rdata_q;

endmodule

### src/sle_ctrl.sv
// Controller of the list engine: checks positions, keeps the length, drives the cell
// row and holds the response register. Depends on sle_pkg and both channel interfaces.
module sle_ctrl #(
	parameter int CAPACITY   = sle_pkg::DEF_CAPACITY,
	parameter int DATA_WIDTH = sle_pkg::DEF_DATA_WIDTH,
	parameter int LW         = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	sle_req_if.sink                req,
	sle_rsp_if.source              rsp,
	output sle_pkg::cell_ctl_t     ctl,
	output logic [LW-1:0]          pos0,
	output logic [DATA_WIDTH-1:0]  wdata,
	output logic [LW-1:0]          len,
	output logic                   scan_start,
	input  logic                   scan_done,
	input  logic [LW-1:0]          scan_found,
	input  logic [DATA_WIDTH-1:0]  scan_rdata
);

	localparam int CW = ((LW > sle_pkg::POS_W) ? LW : sle_pkg::POS_W) + 1;

	sle_pkg::state_t       state_q, state_d;
	logic [LW-1:0]         len_q, len_d;
	logic [LW-1:0]         pos0_q;
	logic [DATA_WIDTH-1:0] qval_q;
	logic                  qget_q;
	logic                  scan_start_q;
	logic                  accept;
	logic [CW-1:0]         pos_w, len_w;
	logic                  ins_err, rd_err;
	logic [DATA_WIDTH-1:0] stored;
	logic                  load_out, start_d, err_d;
	logic [LW-1:0]         found_d;
	logic [DATA_WIDTH-1:0] rdata_d;
	sle_pkg::shift_t       shift_d;
	logic                  out_valid_q;
	logic                  out_err_q;
	logic [sle_pkg::VAL_W-1:0] out_rd_q;
	logic [sle_pkg::POS_W-1:0] out_found_q, out_len_q;

	assign req.ready = (state_q == sle_pkg::ST_IDLE) && (!out_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;
	assign pos_w     = CW'(req.position);
	assign len_w     = CW'(len_q);
	assign ins_err   = (pos_w == '0) || (pos_w > len_w + CW'(1)) || (len_w >= CW'(CAPACITY));
	assign rd_err    = (pos_w == '0) || (pos_w > len_w);
	assign stored    = DATA_WIDTH'($signed(req.item_value));

	always_comb begin
		state_d  = state_q;
		len_d    = len_q;
		shift_d  = sle_pkg::SH_HOLD;
		load_out = 1'b0;
		start_d  = 1'b0;
		err_d    = 1'b0;
		found_d  = '0;
		rdata_d  = '0;
		unique case (state_q)
			sle_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (sle_pkg::op_t'(req.opcode))
						sle_pkg::OP_INSERT: begin
							load_out = 1'b1;
							err_d    = ins_err;
							if (!ins_err) begin
								shift_d = sle_pkg::SH_INSERT;
								len_d   = len_q + LW'(1);
							end
						end
						sle_pkg::OP_DELETE: begin
							load_out = 1'b1;
							err_d    = rd_err;
							if (!rd_err) begin
								shift_d = sle_pkg::SH_DELETE;
								len_d   = len_q - LW'(1);
							end
						end
						sle_pkg::OP_GET: begin
							if (rd_err) begin
								load_out = 1'b1;
								err_d    = 1'b1;
							end else begin
								start_d = 1'b1;
								state_d = sle_pkg::ST_SCAN;
							end
						end
						sle_pkg::OP_LOCATE: begin
							start_d = 1'b1;
							state_d = sle_pkg::ST_SCAN;
						end
						default: ;
					endcase
				end
			end
			sle_pkg::ST_SCAN: begin
				if (scan_done) begin
					load_out = 1'b1;
					found_d  = scan_found;
					rdata_d  = scan_rdata;
					state_d  = sle_pkg::ST_IDLE;
				end
			end
			default: state_d = sle_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= sle_pkg::ST_IDLE;
			len_q        <= '0;
			scan_start_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			len_q        <= len_d;
			scan_start_q <= start_d;
			if (load_out) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos0_q <= LW'(pos_w - CW'(1));
			qval_q <= stored;
			qget_q <= (sle_pkg::op_t'(req.opcode) == sle_pkg::OP_GET);
		end
		if (load_out) begin
			out_err_q   <= err_d;
			out_rd_q    <= sle_pkg::VAL_W'($signed(rdata_d));
			out_found_q <= sle_pkg::POS_W'(found_d);
			out_len_q   <= sle_pkg::POS_W'(len_d);
		end
	end

	// Shifts use the request directly; the scan uses the captured query.
	assign ctl.shift  = shift_d;
	assign ctl.qget   = qget_q;
	assign pos0       = (state_q == sle_pkg::ST_IDLE) ? LW'(pos_w - CW'(1)) : pos0_q;
	assign wdata      = (state_q == sle_pkg::ST_IDLE) ? stored : qval_q;
	assign len        = len_q;
	assign scan_start = scan_start_q;

	assign rsp.valid          = out_valid_q;
	assign rsp.status_error   = out_err_q;
	assign rsp.read_value     = out_rd_q;
	assign rsp.found_position = out_found_q;
	assign rsp.current_length = out_len_q;

`ifndef SYNTH
	a_len_max: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(CAPACITY))
		else $error("list length above capacity");
	a_ins_len: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.opcode == sle_pkg::OP_INSERT && !ins_err)
		|=> len_q == $past(len_q) + LW'(1))
		else $error("insert did not grow the list");
	a_done_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scan_done |-> state_q == sle_pkg::ST_SCAN)
		else $error("scan token arrived outside a scan");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !rsp.ready) |-> !load_out)
		else $error("response register overwritten before transfer");
`endif

endmodule

### src/sequential_list_engine.sv
// Top level of the sequential list engine: controller plus the row of list cells.
// Depends on sle_pkg, sle_req_if, sle_rsp_if, sle_ctrl and sle_cell.

// The list lives in a row of CAPACITY cells, one entry per cell, and needs no clearing
// pass after reset. A valid insert or delete shifts the cells from the position onward
// at the request transfer; for insert, delete and a rejected get the result sits in the
// output register on the next cycle. A valid get and every locate send a token down
// the cell row, one cell per cycle, via the scan start register and each cell's token
// register to the output register. One request is handled at a time; a new one is taken
// once the last is done and the output register is free or emptied in the same cycle.
module sequential_list_engine #(
	parameter int CAPACITY   = sle_pkg::DEF_CAPACITY,
	parameter int DATA_WIDTH = sle_pkg::DEF_DATA_WIDTH
) (
	input  logic      clk,
	input  logic      arst_n,
	sle_req_if.sink   req,
	sle_rsp_if.source rsp
);

	localparam int LW = $clog2(CAPACITY + 1);

	sle_pkg::cell_ctl_t    ctl;
	logic [LW-1:0]         pos0;
	logic [DATA_WIDTH-1:0] wdata;
	logic [LW-1:0]         len;
	logic                  scan_start;
	logic [DATA_WIDTH-1:0] ent [CAPACITY];
	logic                  scan_vld   [CAPACITY+1];
	logic [LW-1:0]         scan_found [CAPACITY+1];
	logic [DATA_WIDTH-1:0] scan_rdata [CAPACITY+1];

	assign scan_vld[0]   = scan_start;
	assign scan_found[0] = '0;
	assign scan_rdata[0] = '0;

	sle_ctrl #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH),
		.LW         (LW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.ctl        (ctl),
		.pos0       (pos0),
		.wdata      (wdata),
		.len        (len),
		.scan_start (scan_start),
		.scan_done  (scan_vld[CAPACITY]),
		.scan_found (scan_found[CAPACITY]),
		.scan_rdata (scan_rdata[CAPACITY])
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_d, right_d;

		if (i == 0) begin : g_first
			assign left_d = wdata;
		end else begin : g_mid
			assign left_d = ent[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_d = ent[i];
		end else begin : g_inner
			assign right_d = ent[i+1];
		end

		sle_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.LW         (LW),
			.INDEX      (i)
		) u_cell (
			.clk            (clk),
			.arst_n         (arst_n),
			.ctl            (ctl),
			.pos0           (pos0),
			.wdata          (wdata),
			.len            (len),
			.left           (left_d),
			.right          (right_d),
			.data           (ent[i]),
			.scan_vld_in    (scan_vld[i]),
			.scan_found_in  (scan_found[i]),
			.scan_rdata_in  (scan_rdata[i]),
			.scan_vld_out   (scan_vld[i+1]),
			.scan_found_out (scan_found[i+1]),
			.scan_rdata_out (scan_rdata[i+1])
		);
	end

endmodule
